>>> src/cgp_pkg.sv
// shared types, constants and tables for the conic gradient core
`timescale 1ns / 1ps
`default_nettype none
package cgp_pkg;

   localparam int CORDIC_STEPS = 18;
   localparam int DIV_STEPS    = 8;
   localparam int VEC_W        = 28;
   localparam int ACC_W        = 20;
   localparam int REM_W        = 25;
   localparam int DEN_W        = 17;

   // register indexes on the csr port
   localparam logic [2:0] REG_CENTER_X    = 3'd0;
   localparam logic [2:0] REG_CENTER_Y    = 3'd1;
   localparam logic [2:0] REG_START_ANGLE = 3'd2;
   localparam logic [2:0] REG_SWEEP_ANGLE = 3'd3;
   localparam logic [2:0] REG_START_COLOR = 3'd4;
   localparam logic [2:0] REG_END_COLOR   = 3'd5;

   // atan(2^-i) in 2^-20 turn units
   localparam logic [ACC_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      20'd131072, 20'd77376, 20'd40884, 20'd20753, 20'd10417, 20'd5213,
      20'd2607, 20'd1304, 20'd652, 20'd326, 20'd163, 20'd81,
      20'd41, 20'd20, 20'd10, 20'd5, 20'd3, 20'd1
   };

   typedef struct packed {
      logic                    valid;
      logic                    zero;
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic [ACC_W-1:0]        acc;
   } cordic_stage_type;

   typedef struct packed {
      logic             valid;
      logic             use_div;
      logic [7:0]       alt_w;
      logic [REM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [7:0]       quo;
   } div_stage_type;

endpackage
`default_nettype wire

>>> src/cgp_ifs.sv
// valid/ready channel interfaces for pixel items and color items
`timescale 1ns / 1ps
`default_nettype none
interface cgp_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface cgp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

>>> src/cgp_cordic_cell.sv
// one vectoring cordic step with its own stage register
`timescale 1ns / 1ps
`default_nettype none
module cgp_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        en,
   input  cgp_pkg::cordic_stage_type  stage_in,
   output cgp_pkg::cordic_stage_type  stage_out
);
   cgp_pkg::cordic_stage_type stage_ff;
   logic signed [cgp_pkg::VEC_W-1:0] xs;
   logic signed [cgp_pkg::VEC_W-1:0] ys;
   logic                             y_pos;

   assign xs    = stage_in.x >>> STEP;
   assign ys    = stage_in.y >>> STEP;
   assign y_pos = !stage_in.y[cgp_pkg::VEC_W-1] && (stage_in.y != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (en) begin
         stage_ff.zero <= stage_in.zero;
         if (y_pos) begin
            stage_ff.x   <= stage_in.x + ys;
            stage_ff.y   <= stage_in.y - xs;
            stage_ff.acc <= stage_in.acc + cgp_pkg::ATAN_TABLE[STEP];
         end else begin
            stage_ff.x   <= stage_in.x - ys;
            stage_ff.y   <= stage_in.y + xs;
            stage_ff.acc <= stage_in.acc - cgp_pkg::ATAN_TABLE[STEP];
         end
      end
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

>>> src/cgp_div_cell.sv
// one restoring division step, one quotient bit
`timescale 1ns / 1ps
`default_nettype none
module cgp_div_cell #(
   parameter int BIT = 7
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     en,
   input  cgp_pkg::div_stage_type  stage_in,
   output cgp_pkg::div_stage_type  stage_out
);
   cgp_pkg::div_stage_type stage_ff;
   logic [cgp_pkg::REM_W:0] trial;
   logic                    fits;

   assign trial = ({1'b0, 8'b0, stage_in.den} << BIT);
   assign fits  = {1'b0, stage_in.rem} >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (en) begin
         stage_ff.use_div <= stage_in.use_div;
         stage_ff.alt_w   <= stage_in.alt_w;
         stage_ff.den     <= stage_in.den;
         if (fits) begin
            stage_ff.rem <= cgp_pkg::REM_W'({1'b0, stage_in.rem} - trial);
            stage_ff.quo <= stage_in.quo | (8'd1 << BIT);
         end else begin
            stage_ff.rem <= stage_in.rem;
            stage_ff.quo <= stage_in.quo;
         end
      end
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

>>> src/conic_gradient_pixel_color_core.sv
// conic gradient color core: cordic cell chain, divider cell chain, blend
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake          payload
// req_item  in   valid/ready        pixel_x[11:0] pixel_y[11:0]
// rsp_item  out  valid/ready        red[7:0] green[7:0] blue[7:0]
// csr_*     in   csr_we, no ready   csr_index[2:0] csr_wdata[23:0]
//
// one item per clock while the output register is empty or taken; stages: input stage,
// 18 cordic cells, decision stage, 8 divider cells, output register
// the whole pipe advances together whenever the output register is empty or taken
// synchronous active-high reset clears valids and loads register defaults
module conic_gradient_pixel_color_core #(
   parameter int MAX_DIM = 4096
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [23:0] csr_wdata,
   cgp_req_if.sink     req_item,
   cgp_rsp_if.source   rsp_item
);
   localparam logic [12:0] MaxDim = 13'(MAX_DIM);
   localparam logic [11:0] MaxPix = 12'(MAX_DIM - 1);

   // configuration registers
   logic [15:0] center_x_ff, center_y_ff, start_angle_ff;
   logic [17:0] sweep_ff;
   logic [23:0] start_color_ff, end_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         start_angle_ff <= '0;
         sweep_ff       <= 18'h10000;
         start_color_ff <= '0;
         end_color_ff   <= 24'hFFFFFF;
      end else if (csr_we) begin
         unique case (csr_index)
            cgp_pkg::REG_CENTER_X:    center_x_ff    <= csr_wdata[15:0];
            cgp_pkg::REG_CENTER_Y:    center_y_ff    <= csr_wdata[15:0];
            cgp_pkg::REG_START_ANGLE: start_angle_ff <= csr_wdata[15:0];
            cgp_pkg::REG_SWEEP_ANGLE: sweep_ff       <= csr_wdata[17:0];
            cgp_pkg::REG_START_COLOR: start_color_ff <= csr_wdata;
            cgp_pkg::REG_END_COLOR:   end_color_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipe advance: the output register is free or being drained
   logic rsp_valid_ff;
   logic adv;
   assign adv            = !rsp_valid_ff || rsp_item.ready;
   assign req_item.ready = adv;

   // input stage: clamp, vector to pixel centre, fold into right half plane
   logic [11:0]        px_sat, py_sat;
   logic signed [17:0] dx, dy;
   logic signed [cgp_pkg::VEC_W-1:0] dx_ext, dy_ext;
   cgp_pkg::cordic_stage_type c0_in;
   cgp_pkg::cordic_stage_type c0_ff;

   assign px_sat = ({1'b0, req_item.pixel_x} >= MaxDim) ? MaxPix : req_item.pixel_x;
   assign py_sat = ({1'b0, req_item.pixel_y} >= MaxDim) ? MaxPix : req_item.pixel_y;
   assign dx = $signed({2'b00, px_sat, 4'h8}) - $signed({2'b00, center_x_ff});
   assign dy = $signed({2'b00, py_sat, 4'h8}) - $signed({2'b00, center_y_ff});
   assign dx_ext = {{(cgp_pkg::VEC_W-18){dx[17]}}, dx};
   assign dy_ext = {{(cgp_pkg::VEC_W-18){dy[17]}}, dy};

   always_comb begin
      c0_in.valid = req_item.valid;
      c0_in.zero  = (dx == '0) && (dy == '0);
      if (dx[17]) begin
         // left half plane: negate and start at half a turn
         c0_in.x   = (-dx_ext) <<< 8;
         c0_in.y   = (-dy_ext) <<< 8;
         c0_in.acc = 20'h80000;
      end else begin
         c0_in.x   = dx_ext <<< 8;
         c0_in.y   = dy_ext <<< 8;
         c0_in.acc = '0;
      end
   end

   cgp_pkg::cordic_stage_type cstage [cgp_pkg::CORDIC_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff.valid <= 1'b0;
      end else if (adv) begin
         c0_ff.valid <= c0_in.valid;
      end
      if (adv) begin
         c0_ff.zero <= c0_in.zero;
         c0_ff.x    <= c0_in.x;
         c0_ff.y    <= c0_in.y;
         c0_ff.acc  <= c0_in.acc;
      end
   end

   assign cstage[0] = c0_ff;

   // chain of cordic cells, one rotation each
   for (genvar i = 0; i < cgp_pkg::CORDIC_STEPS; i++) begin : g_cordic
      cgp_cordic_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .stage_in  (cstage[i]),
         .stage_out (cstage[i+1])
      );
   end

   // decision stage: angle, phase, mode and divider operands
   cgp_pkg::cordic_stage_type ctail;
   logic [19:0] acc_rnd;
   logic [15:0] angle, d0, d;
   logic        sw_neg, full, zero_sw, in_sweep, near_start;
   logic [18:0] sw_ext, mag;
   logic [16:0] m, ds, de, d17, e17;
   logic [15:0] e;
   logic [23:0] d255;
   logic [7:0]  full_w, alt_w;
   cgp_pkg::div_stage_type dv_in;
   cgp_pkg::div_stage_type dv_ff;

   assign ctail   = cstage[cgp_pkg::CORDIC_STEPS];
   assign acc_rnd = ctail.acc + 20'd8;
   assign angle   = ctail.zero ? 16'd0 : acc_rnd[19:4];
   assign d0      = angle - start_angle_ff;
   assign sw_neg  = sweep_ff[17];
   assign d       = sw_neg ? 16'(-d0) : d0;
   assign sw_ext  = {sweep_ff[17], sweep_ff};
   assign mag     = sw_neg ? 19'(-sw_ext) : sw_ext;
   assign full    = mag >= 19'h10000;
   assign zero_sw = mag == '0;
   assign m       = full ? 17'h10000 : mag[16:0];
   assign d17     = {1'b0, d};
   assign in_sweep = d17 <= m;
   assign d255    = {d, 8'b0} - {8'b0, d} + 24'd32768;
   assign full_w  = d255[23:16];
   // outside the sweep: snap to the nearer end, ties to the start
   assign e       = 16'(d17 - m);
   assign e17     = {1'b0, e};
   assign ds      = (d17 <= 17'h08000) ? d17 : 17'h10000 - d17;
   assign de      = (e17 <= 17'h08000) ? e17 : 17'h10000 - e17;
   assign near_start = ds <= de;

   always_comb begin
      priority if (full) begin
         alt_w = full_w;
      end else if (zero_sw) begin
         alt_w = 8'd0;
      end else begin
         alt_w = near_start ? 8'd0 : 8'd255;
      end
      dv_in.valid   = ctail.valid;
      dv_in.use_div = !full && !zero_sw && in_sweep;
      dv_in.alt_w   = alt_w;
      // round(d*255/m) as (510 d + m) / (2 m)
      dv_in.rem     = {d, 9'b0} - {8'b0, d, 1'b0} + {8'b0, m};
      dv_in.den     = {m[15:0], 1'b0};
      dv_in.quo     = '0;
   end

   cgp_pkg::div_stage_type dstage [cgp_pkg::DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff.valid <= 1'b0;
      end else if (adv) begin
         dv_ff.valid <= dv_in.valid;
      end
      if (adv) begin
         dv_ff.use_div <= dv_in.use_div;
         dv_ff.alt_w   <= dv_in.alt_w;
         dv_ff.rem     <= dv_in.rem;
         dv_ff.den     <= dv_in.den;
         dv_ff.quo     <= dv_in.quo;
      end
   end

   assign dstage[0] = dv_ff;

   // chain of divider cells, msb of the quotient first
   for (genvar j = 0; j < cgp_pkg::DIV_STEPS; j++) begin : g_div
      cgp_div_cell #(.BIT(cgp_pkg::DIV_STEPS - 1 - j)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .stage_in  (dstage[j]),
         .stage_out (dstage[j+1])
      );
   end

   // blend stage into the output register
   cgp_pkg::div_stage_type dtail;
   logic [7:0]  w;
   logic [8:0]  a;
   logic [23:0] blend;

   assign dtail = dstage[cgp_pkg::DIV_STEPS];
   assign w     = dtail.use_div ? dtail.quo : dtail.alt_w;
   assign a     = {1'b0, w} + {8'b0, w[7]};

   always_comb begin
      logic signed [9:0]  s_ch, e_ch, diff;
      logic signed [19:0] prod;
      logic signed [11:0] r;
      blend = '0;
      for (int k = 0; k < 3; k++) begin
         s_ch = $signed({2'b00, start_color_ff[8*k +: 8]});
         e_ch = $signed({2'b00, end_color_ff[8*k +: 8]});
         diff = e_ch - s_ch;
         prod = $signed({1'b0, a}) * diff;
         r    = 12'(s_ch) + 12'(prod >>> 8);
         if (r < 0) begin
            blend[8*k +: 8] = 8'd0;
         end else if (r > 12'sd255) begin
            blend[8*k +: 8] = 8'd255;
         end else begin
            blend[8*k +: 8] = r[7:0];
         end
      end
   end

   logic [23:0] rgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dtail.valid;
      end
      if (adv) begin
         rgb_ff <= blend;
      end
   end

   assign rsp_item.valid = rsp_valid_ff;
   assign rsp_item.red   = rgb_ff[23:16];
   assign rsp_item.green = rgb_ff[15:8];
   assign rsp_item.blue  = rgb_ff[7:0];

   // a finished item at the divider tail lands in the output register
   assert property (@(posedge clock) disable iff (reset)
      adv && dtail.valid |=> rsp_valid_ff)
      else $error("item lost between divider tail and output");

   // divider operands keep the quotient below 256
   assert property (@(posedge clock) disable iff (reset)
      dv_in.valid && dv_in.use_div |->
         ({1'b0, dv_in.rem} < ({9'b0, dv_in.den} << 8)))
      else $error("divider quotient would overflow");

   // a stalled pipe holds its cordic tail
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(ctail))
      else $error("cordic tail moved during stall");

   // the left half plane fold leaves x non-negative
   assert property (@(posedge clock) disable iff (reset)
      cstage[0].valid |-> !cstage[0].x[cgp_pkg::VEC_W-1])
      else $error("cordic start vector not folded");
endmodule
`default_nettype wire
